FILE: hw/rtl/esc_pkg.sv
package esc_pkg;

    localparam int unsigned LAST_YEAR_DEF = 2099;
    localparam int unsigned FIRST_YEAR    = 2012;
    localparam int unsigned EPOCH_YEAR    = 1970;
    localparam int unsigned YEAR_W        = 12;
    localparam int unsigned DAYS_W        = 16;

    // Packed stage payload carried between pipeline stages.
    typedef struct packed {
        logic [5:0]  sec;
        logic [5:0]  min;
        logic [4:0]  hr;
        logic [15:0] days;
    } esc_tod_t;

    // Days before the start of month m in a common year.
    function automatic logic [8:0] month_start(input logic [3:0] m);
        logic [8:0] r;
        case (m)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd31;
            4'd2:    r = 9'd59;
            4'd3:    r = 9'd90;
            4'd4:    r = 9'd120;
            4'd5:    r = 9'd151;
            4'd6:    r = 9'd181;
            4'd7:    r = 9'd212;
            4'd8:    r = 9'd243;
            4'd9:    r = 9'd273;
            4'd10:   r = 9'd304;
            4'd11:   r = 9'd334;
            default: r = 9'd365;
        endcase
        return r;
    endfunction

    function automatic logic is_leap(input logic [YEAR_W-1:0] y);
        // 1970..2106 holds only 2000 and 2100 as century years; 2000 is leap.
        return (y[1:0] == 2'b00) && (y != 12'd2100);
    endfunction

endpackage

FILE: hw/rtl/esc_divmod.sv
// Divides by a small constant through a reciprocal multiply and one correction.
module esc_divmod #(
    parameter int unsigned IN_W  = 32,
    parameter int unsigned DIVISOR = 60,
    parameter int unsigned Q_W   = 26,
    parameter int unsigned R_W   = 6
) (
    input  logic [IN_W-1:0] num,
    output logic [Q_W-1:0]  quo,
    output logic [R_W-1:0]  rem
);
    // With this shift the reciprocal fits in IN_W+1 bits and the estimate is
    // at most one below the true quotient.
    localparam int unsigned SH = IN_W + $clog2(DIVISOR);
    localparam logic [IN_W:0] RECIP = (IN_W+1)'(((64'd1 << SH) / DIVISOR));
    logic [2*IN_W:0] prod;
    logic [IN_W-1:0] q0;
    logic [IN_W+6:0] back;
    logic [IN_W-1:0] r0;

    always_comb
    begin
        prod = {{IN_W{1'b0}}, RECIP} * {{(IN_W+1){1'b0}}, num};
        q0   = IN_W'(prod >> SH);
        back = (IN_W+7)'(q0) * (IN_W+7)'(DIVISOR);
        r0   = num - IN_W'(back);
        if (r0 >= IN_W'(DIVISOR))
        begin
            quo = Q_W'(q0 + 1'b1);
            rem = R_W'(r0 - IN_W'(DIVISOR));
        end
        else
        begin
            quo = Q_W'(q0);
            rem = R_W'(r0);
        end
    end
endmodule

FILE: hw/rtl/epoch_seconds_to_calendar.sv
// Converts seconds since 1970-01-01 UTC into calendar fields. Fully pipelined:
// one transfer may enter every cycle while the output is not stalled. Its stages
// are the chain of constant divisions, the weekday and year estimate, the year
// and month searches and the summer-time flag. Backpressure stalls all stages.
module epoch_seconds_to_calendar #(
    parameter int unsigned LAST_YEAR = esc_pkg::LAST_YEAR_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // epoch_seconds[31:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // second[5:0], minute[11:6], hour[16:12], day[21:17], month[25:22],
    // year[37:26], weekday[40:38], summer[41], out_of_range[42], zero pad
    output logic [47:0] m_axis_tdata
);
    import esc_pkg::*;

    localparam int unsigned NS = 7;
    logic [NS-1:0] v_reg;
    logic          adv;

    assign adv           = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;
    assign m_axis_tvalid = v_reg[NS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[NS-2:0], s_axis_tvalid};
    end

    // Stage 1: seconds and minutes.
    logic [26:0] m1_q; logic [5:0] s1_r;
    esc_divmod #(.IN_W(32), .DIVISOR(60), .Q_W(27), .R_W(6)) u_d60a
        (.num(s_axis_tdata), .quo(m1_q), .rem(s1_r));
    logic [26:0] min_tot_reg; logic [5:0] sec1_reg;

    // Stage 2: minutes of hour.
    logic [20:0] h2_q; logic [5:0] m2_r;
    esc_divmod #(.IN_W(27), .DIVISOR(60), .Q_W(21), .R_W(6)) u_d60b
        (.num(min_tot_reg), .quo(h2_q), .rem(m2_r));
    logic [20:0] hr_tot_reg; logic [5:0] sec2_reg, min2_reg;

    // Stage 3: hours and days.
    logic [15:0] d3_q; logic [4:0] h3_r;
    esc_divmod #(.IN_W(21), .DIVISOR(24), .Q_W(16), .R_W(5)) u_d24
        (.num(hr_tot_reg), .quo(d3_q), .rem(h3_r));
    esc_tod_t tod3_reg;

    // Stage 4: weekday and a year estimate from days/366.
    logic [2:0]  wd4;
    logic [15:0] wq_unused;
    logic [16:0] wd_num;
    assign wd_num = {1'b0, tod3_reg.days} + 17'd3;
    esc_divmod #(.IN_W(17), .DIVISOR(7), .Q_W(16), .R_W(3)) u_d7
        (.num(wd_num), .quo(wq_unused), .rem(wd4));
    logic [7:0] yest4;
    logic [15:0] yq_full; logic [8:0] yr_unused;
    esc_divmod #(.IN_W(16), .DIVISOR(366), .Q_W(16), .R_W(9)) u_d366
        (.num(tod3_reg.days), .quo(yq_full), .rem(yr_unused));
    assign yest4 = yq_full[7:0];
    esc_tod_t tod4_reg; logic [2:0] wd4_reg; logic [7:0] yest4_reg;

    // Stage 5: days before the estimated year; the true year is est or est+1.
    function automatic logic [15:0] ystart(input logic [7:0] k);
        logic [15:0] n, l4, l100;
        begin
            // Leap years strictly before 1970+k, counted from 1970.
            n    = 16'(k) + 16'd1969;
            l4   = (n >> 2) - 16'd492;
            l100 = (n >= 16'd2100) ? 16'd1 : 16'd0;
            return 16'(k) * 16'd365 + l4 - l100;
        end
    endfunction
    logic [15:0] ys_a, ys_b;
    assign ys_a = ystart(yest4_reg);
    assign ys_b = ystart(yest4_reg + 8'd1);
    esc_tod_t tod5_reg; logic [2:0] wd5_reg;
    logic [YEAR_W-1:0] year5_reg; logic [15:0] ys5_reg;

    // Stage 6: month search over the year's days.
    logic [8:0]  doy6;
    logic        lp6;
    logic [3:0]  mon6;
    logic [8:0]  ms6;
    assign doy6 = 9'(tod5_reg.days - ys5_reg);
    assign lp6  = is_leap(year5_reg);
    always_comb
    begin
        mon6 = 4'd0;
        for (int i = 1; i < 12; i++)
        begin
            if (doy6 >= month_start(4'(i)) + ((lp6 && i >= 2) ? 9'd1 : 9'd0))
                mon6 = 4'(i);
        end
        ms6 = month_start(mon6) + ((lp6 && mon6 >= 4'd2) ? 9'd1 : 9'd0);
    end
    logic [4:0]  dom6_reg; logic [3:0] mon6_reg;
    logic [5:0]  sec6_reg, min6_reg; logic [4:0] hr6_reg;
    logic [2:0]  wd6_reg; logic [YEAR_W-1:0] year6_reg;
    logic [2:0]  wdm6_reg;

    // Stage 7: summer time and range flag.
    // Weekday of the current day is known; the last Sunday of a 31-day month
    // is the day whose offset from today matches the Sunday distance.
    // Remainder by seven for values below 56, by conditional subtraction.
    function automatic logic [2:0] mod7(input logic [5:0] x);
        logic [5:0] r;
        r = x;
        if (r >= 6'd28)
            r = r - 6'd28;
        if (r >= 6'd14)
            r = r - 6'd14;
        if (r >= 6'd7)
            r = r - 6'd7;
        return r[2:0];
    endfunction
    logic [5:0]  to_end7;
    logic [2:0]  wd_last7;
    logic [4:0]  lsun7;
    logic        after7, before7, oor7;
    always_comb
    begin
        to_end7  = 6'd30 - 6'(dom6_reg);
        wd_last7 = mod7(6'(wd6_reg) + to_end7);
        lsun7    = 5'd30 - ((wd_last7 == 3'd6) ? 5'd0 : 5'(wd_last7) + 5'd1);
        after7   = (mon6_reg > 4'd2) || (mon6_reg == 4'd2 &&
                   (dom6_reg > lsun7 || (dom6_reg == lsun7 && hr6_reg >= 5'd1)));
        before7  = (mon6_reg < 4'd9) || (mon6_reg == 4'd9 &&
                   (dom6_reg < lsun7 || (dom6_reg == lsun7 && hr6_reg < 5'd1)));
        oor7     = (year6_reg < YEAR_W'(FIRST_YEAR)) || (year6_reg > YEAR_W'(LAST_YEAR));
    end
    logic [47:0] out_reg;
    assign m_axis_tdata = out_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            min_tot_reg <= m1_q;
            sec1_reg    <= s1_r;
            hr_tot_reg  <= h2_q;
            sec2_reg    <= sec1_reg;
            min2_reg    <= m2_r;
            tod3_reg    <= '{sec: sec2_reg, min: min2_reg, hr: h3_r, days: d3_q};
            tod4_reg    <= tod3_reg;
            wd4_reg     <= wd4;
            yest4_reg   <= yest4;
            tod5_reg    <= tod4_reg;
            wd5_reg     <= wd4_reg;
            if (tod4_reg.days >= ys_b)
            begin
                year5_reg <= YEAR_W'(EPOCH_YEAR) + YEAR_W'(yest4_reg) + 1'b1;
                ys5_reg   <= ys_b;
            end
            else
            begin
                year5_reg <= YEAR_W'(EPOCH_YEAR) + YEAR_W'(yest4_reg);
                ys5_reg   <= ys_a;
            end
            dom6_reg  <= 5'(doy6 - ms6);
            mon6_reg  <= mon6;
            sec6_reg  <= tod5_reg.sec;
            min6_reg  <= tod5_reg.min;
            hr6_reg   <= tod5_reg.hr;
            wd6_reg   <= wd5_reg;
            wdm6_reg  <= wd5_reg;
            year6_reg <= year5_reg;
            out_reg   <= {5'd0, oor7, after7 && before7, wd6_reg, year6_reg, mon6_reg,
                          dom6_reg, hr6_reg, min6_reg, sec6_reg};
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed under stall");
    assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[NS-2] |-> mon6_reg <= 4'd11)
        else $error("month out of range");
    assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[NS-2] |-> wd6_reg == wdm6_reg && wd6_reg <= 3'd6)
        else $error("weekday out of range");
endmodule

FILE: sim/epoch_seconds_to_calendar_test.sv
module epoch_seconds_to_calendar_test;

    typedef struct packed {
        logic        oor;
        logic        summer;
        logic [2:0]  wday;
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hr;
        logic [5:0]  min;
        logic [5:0]  sec;
    } calendar_t;

    localparam int unsigned WATCHDOG_LIMIT = 20000;
    localparam int unsigned LONG_HOLD      = 300;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // epoch_seconds[31:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // second[5:0], minute[11:6], hour[16:12], day[21:17], month[25:22],
    // year[37:26], weekday[40:38], summer[41], out_of_range[42], zero pad
    logic [47:0] m_axis_tdata;

    logic [31:0] pending_seconds[$];
    calendar_t   expected_dates[$];
    int unsigned mismatch_count;
    int unsigned idle_cycles;
    int unsigned send_gap;
    int unsigned recv_gap;
    int unsigned hold_count;
    bit          hold_request;
    bit          drain_request;
    bit          timed_out;

    epoch_seconds_to_calendar u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    function automatic bit leap_year(int unsigned y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic int unsigned days_in_month(int unsigned m, int unsigned y);
        int unsigned lengths[12];
        lengths = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        if (m == 1 && leap_year(y))
        begin
            return 29;
        end
        return lengths[m];
    endfunction

    // Day of the month (0-based) of the last Sunday of month m of year y.
    function automatic int unsigned last_sunday(int unsigned m, int unsigned y,
                                                int unsigned jan1_wday);
        int unsigned doy;
        int unsigned wd;
        doy = 0;
        for (int unsigned i = 0; i <= m; i++)
        begin
            doy += days_in_month(i, y);
        end
        wd = (jan1_wday + doy - 1) % 7;
        return 30 - (wd + 1) % 7;
    endfunction

    function automatic calendar_t convert_epoch(logic [31:0] secs);
        calendar_t   c;
        longint unsigned t;
        int unsigned days;
        int unsigned year;
        int unsigned ystart;
        int unsigned month;
        int unsigned ylen;
        int unsigned hr;
        int unsigned mar_day;
        int unsigned oct_day;
        int unsigned jan1;
        bit          after_start;
        bit          before_end;
        t = 64'(secs);
        c.sec = 6'(t % 60);
        t = t / 60;
        c.min = 6'(t % 60);
        t = t / 60;
        hr = 32'(t % 24);
        c.hr = 5'(hr);
        days = 32'(t / 24);
        c.wday = 3'((3 + days) % 7);
        year = 1970;
        ystart = 0;
        forever
        begin
            ylen = leap_year(year) ? 366 : 365;
            if (days < ylen)
            begin
                break;
            end
            days -= ylen;
            ystart += ylen;
            year++;
        end
        month = 0;
        while (month < 11 && days >= days_in_month(month, year))
        begin
            days -= days_in_month(month, year);
            month++;
        end
        jan1 = (3 + ystart) % 7;
        mar_day = last_sunday(2, year, jan1);
        oct_day = last_sunday(9, year, jan1);
        after_start = month > 2 ||
            (month == 2 && (days > mar_day || (days == mar_day && hr >= 1)));
        before_end = month < 9 ||
            (month == 9 && (days < oct_day || (days == oct_day && hr < 1)));
        c.day = 5'(days);
        c.month = 4'(month);
        c.year = 12'(year);
        c.summer = after_start && before_end;
        c.oor = year < esc_pkg::FIRST_YEAR || year > esc_pkg::LAST_YEAR_DEF;
        return c;
    endfunction

    function automatic int unsigned random_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 93)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // Seconds at a given day count and time of day.
    function automatic logic [31:0] at_day(int unsigned days, int unsigned secs);
        return days * 86400 + secs;
    endfunction

    // Day count of the last Sunday of month m of year y.
    function automatic int unsigned dst_sunday(int unsigned y, int unsigned m);
        int unsigned d;
        d = 0;
        for (int unsigned yy = 1970; yy < y; yy++)
        begin
            d += leap_year(yy) ? 366 : 365;
        end
        for (int unsigned mm = 0; mm <= m; mm++)
        begin
            d += days_in_month(mm, y);
        end
        d = d - 1;
        while ((3 + d) % 7 != 6)
        begin
            d--;
        end
        return d;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        int unsigned y;
        int unsigned d;
        int unsigned r;
        pending_seconds.push_back(32'd0);
        pending_seconds.push_back(32'hFFFF_FFFF);
        pending_seconds.push_back(32'd4102444799);
        pending_seconds.push_back(32'd4102444800);
        pending_seconds.push_back(32'd1325376000);
        pending_seconds.push_back(32'd1325375999);
        pending_seconds.push_back(32'd951782400);
        pending_seconds.push_back(32'd951868800);
        pending_seconds.push_back(32'd946684799);
        pending_seconds.push_back(32'h5555_5555);
        pending_seconds.push_back(32'hAAAA_AAAA);
        pending_seconds.push_back(32'd4107542400);
        d = dst_sunday(2020, 2);
        pending_seconds.push_back(at_day(d, 3599));
        pending_seconds.push_back(at_day(d, 3600));
        d = dst_sunday(2020, 9);
        pending_seconds.push_back(at_day(d, 3599));
        pending_seconds.push_back(at_day(d, 3600));
        d = dst_sunday(1999, 2);
        pending_seconds.push_back(at_day(d, 3600));
        for (int i = 0; i < 1533; i++)
        begin
            r = $urandom_range(0, 9);
            if (r < 4)
            begin
                pending_seconds.push_back($urandom());
            end
            else if (r < 8)
            begin
                y = $urandom_range(1971, 2105);
                d = dst_sunday(y, (r < 6) ? 2 : 9);
                pending_seconds.push_back(at_day(d, $urandom_range(0, 7200)));
            end
            else
            begin
                y = $urandom_range(1972, 2104);
                d = dst_sunday(y, 0) - 1 - $urandom_range(0, 30);
                pending_seconds.push_back(at_day(d, $urandom_range(86300, 86399) - 86300 +
                                                 (r == 8 ? 86300 : 0)));
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Sender: offers items from the queue, with random gaps and one pause to drain the pipeline.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            send_gap      <= 0;
            drain_request <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_dates.push_back(convert_epoch(s_axis_tdata));
                void'(pending_seconds.pop_front());
            end
            if (pending_seconds.size() == 1000 && !drain_request)
            begin
                drain_request <= 1'b1;
            end
            if (s_axis_tvalid && !s_axis_tready)
            begin
                // Hold the offered item until it is taken.
            end
            else if (drain_request && pending_seconds.size() <= 1000 &&
                     (expected_dates.size() != 0 || (s_axis_tvalid && s_axis_tready)))
            begin
                s_axis_tvalid <= 1'b0;
            end
            else if (send_gap != 0)
            begin
                send_gap      <= send_gap - 1;
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_seconds.size() != 0)
            begin
                // The accepted item has already left the queue, so the head is next.
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= pending_seconds[0];
                if (pending_seconds.size() < 1400 && pending_seconds.size() > 1100)
                begin
                    send_gap <= 0;
                end
                else
                begin
                    send_gap <= random_gap();
                end
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
            if (drain_request && pending_seconds.size() < 1000 && expected_dates.size() == 0)
            begin
                drain_request <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off while the sender keeps offering.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            recv_gap      <= 0;
            hold_count    <= 0;
            hold_request  <= 1'b0;
            mismatch_count <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_dates.size() == 0)
                begin
                    mismatch_count <= mismatch_count + 1;
                    if (mismatch_count < 10)
                    begin
                        $display("unexpected transfer: %h", m_axis_tdata);
                    end
                end
                else
                begin
                    if (m_axis_tdata !== {5'd0, expected_dates[0]} ||
                        $isunknown(m_axis_tdata))
                    begin
                        mismatch_count <= mismatch_count + 1;
                        if (mismatch_count < 10)
                        begin
                            $display("mismatch: expected %h actual %h",
                                     {5'd0, expected_dates[0]}, m_axis_tdata);
                        end
                    end
                    void'(expected_dates.pop_front());
                end
            end
            if (!hold_request && pending_seconds.size() == 1300)
            begin
                hold_request <= 1'b1;
                hold_count   <= LONG_HOLD;
                m_axis_tready <= 1'b0;
            end
            else if (hold_count != 0)
            begin
                hold_count    <= hold_count - 1;
                m_axis_tready <= 1'b0;
            end
            else if (recv_gap != 0)
            begin
                recv_gap      <= recv_gap - 1;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                recv_gap      <= (pending_seconds.size() < 600 &&
                                  pending_seconds.size() > 400) ? 0 : random_gap();
            end
        end
    end

    // Watchdog: counts cycles without any transfer.
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        timed_out = 1'b0;
        wait (rst_n === 1'b1);
        while ((pending_seconds.size() != 0 || expected_dates.size() != 0) && !timed_out)
        begin
            @(posedge clk);
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                timed_out = 1'b1;
            end
        end
        if (!timed_out)
        begin
            repeat (50) @(posedge clk);
        end
        if (!timed_out && mismatch_count == 0 && expected_dates.size() == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
